>>> design/kvt_pkg.sv
// kvt_pkg: shared operation codes and the beat record that walks the cell row
// of the keyed value table. No dependencies.
`timescale 1ns / 1ps

package kvt_pkg;

   // operation codes carried by req_op
   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_LOOKUP = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   // status codes on rsp_status
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_RANGE     = 2'd3;

   // one operation in flight along the row of cells
   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] key;      // normalized key, later the copied entry key
      logic [31:0] value;    // masked value, later the copied entry value
      logic [6:0]  slot;
      logic        slot_ok;  // slot lies below the fill count
      logic        hit;      // some cell claimed the beat
      logic        app;      // a free cell took the push as a new entry
   } beat_type;

endpackage

>>> design/kvt_cell.sv
// kvt_cell: one table entry plus one stage of the operation beat row.
// Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_cell
   import kvt_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int KW    = 64,
   parameter int VW    = 32,
   parameter int IW    = 7,
   parameter int FW    = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [FW-1:0] fill,
   input  beat_type      up_beat,
   input  logic          up_valid,
   input  logic [IW-1:0] up_index,
   output beat_type      dn_beat,
   output logic          dn_valid,
   output logic [IW-1:0] dn_index
);

   localparam logic [FW-1:0] MY_FILL = FW'(INDEX);
   localparam logic [IW-1:0] MY_IDX  = IW'(INDEX);

   logic [KW-1:0] key_ff,   key_in;
   logic [VW-1:0] value_ff, value_in;
   beat_type      beat_ff,  beat_in;
   logic          valid_ff;
   logic [IW-1:0] index_ff, index_in;

   logic occupied;
   logic match;

   assign occupied = MY_FILL < fill;
   assign match    = occupied && (key_ff == up_beat.key[KW-1:0]);

   // act on the passing beat
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      beat_in  = up_beat;
      index_in = up_index;
      if (up_valid) begin
         case (up_beat.op)
            OP_PUSH: begin
               if (!up_beat.hit && !up_beat.app) begin
                  if (match) begin
                     value_in    = up_beat.value[VW-1:0];
                     beat_in.hit = 1'b1;
                     index_in    = MY_IDX;
                  end else if (MY_FILL == fill) begin
                     key_in      = up_beat.key[KW-1:0];
                     value_in    = up_beat.value[VW-1:0];
                     beat_in.app = 1'b1;
                     index_in    = MY_IDX;
                  end
               end
            end
            OP_LOOKUP: begin
               if (!up_beat.hit && match) begin
                  beat_in.hit   = 1'b1;
                  beat_in.key   = 64'(key_ff);
                  beat_in.value = 32'(value_ff);
                  index_in      = MY_IDX;
               end
            end
            OP_DELETE: begin
               if (match) begin
                  key_in   = '0;
                  value_in = '0;
                  if (!up_beat.hit) begin
                     beat_in.hit = 1'b1;
                     index_in    = MY_IDX;
                  end
               end
            end
            OP_CLEAR: begin
               if (occupied) begin
                  key_in   = '0;
                  value_in = '0;
               end
            end
            OP_READ: begin
               if (up_beat.slot_ok && (32'(up_beat.slot) == 32'(INDEX))) begin
                  beat_in.hit   = 1'b1;
                  beat_in.key   = 64'(key_ff);
                  beat_in.value = 32'(value_ff);
                  index_in      = MY_IDX;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      beat_ff  <= beat_in;
      index_ff <= index_in;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= up_valid;
   end

   assign dn_beat  = beat_ff;
   assign dn_valid = valid_ff;
   assign dn_index = index_ff;

endmodule

>>> design/keyed_value_table_unit.sv
// keyed_value_table_unit: top level of the keyed value table, a row of
// entry cells with request capture, fill count and response formatting.
// Depends on kvt_pkg and kvt_cell.
`timescale 1ns / 1ps

// An operation is taken when start is high and busy is low. It enters the
// row of DEPTH cells and moves one cell per clock; each cell compares, updates
// or reports its own entry as the beat passes. The response is registered
// once the beat leaves the last cell and appears on the rsp_ ports, flagged by
// rsp_strobe for one cycle; it cannot be held off, so capture it when it is
// strobed. busy drops in the strobe cycle, so a new operation can be taken
// only after the previous one has walked the whole cell row.
// No clearing pass is needed after reset.
module keyed_value_table_unit
   import kvt_pkg::*;
#(
   parameter int DEPTH      = 128,
   parameter int KEY_BYTES  = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [63:0] req_key,
   input  logic [31:0] req_value,
   input  logic [6:0]  req_slot,
   output logic        rsp_strobe,
   output logic        rsp_found,
   output logic [6:0]  rsp_entry_index,
   output logic [63:0] rsp_entry_key,
   output logic [31:0] rsp_entry_value,
   output logic [1:0]  rsp_status
);

   localparam int KW = 8 * KEY_BYTES;
   localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int IW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam logic [31:0] VMASK = (VW == 32) ? 32'hFFFF_FFFF : 32'((64'd1 << VW) - 64'd1);
   localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_BUSY = 2'b10
   } state_type;

   state_type     state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   beat_type      beat_ff, beat_in;
   logic          inject_ff;

   logic          accept;
   logic [63:0]   norm_key;
   logic          stop;

   beat_type      chain_beat  [DEPTH+1];
   logic          chain_valid [DEPTH+1];
   logic [IW-1:0] chain_index [DEPTH+1];
   logic [DEPTH-1:0] cell_busy;

   beat_type      last_beat;
   logic          last_valid;
   logic [31:0]   last_idx32;

   logic          strobe_ff;
   logic          found_ff, found_in;
   logic [6:0]    index_ff, index_in;
   logic [63:0]   ekey_ff, ekey_in;
   logic [31:0]   evalue_ff, evalue_in;
   logic [1:0]    status_ff, status_in;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // key ends at its first zero byte or at KEY_BYTES
   always_comb begin
      norm_key = '0;
      stop     = 1'b0;
      for (int b = 0; b < 8; b++) begin
         if (b >= KEY_BYTES || req_key[8*b +: 8] == 8'h00) stop = 1'b1;
         if (!stop) norm_key[8*b +: 8] = req_key[8*b +: 8];
      end
   end

   // request capture
   always_comb begin
      beat_in         = beat_ff;
      if (accept) begin
         beat_in.op      = req_op;
         beat_in.key     = norm_key;
         beat_in.value   = req_value & VMASK;
         beat_in.slot    = req_slot;
         beat_in.slot_ok = 32'(req_slot) < 32'(fill_ff);
         beat_in.hit     = 1'b0;
         beat_in.app     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   // cell row
   assign chain_beat[0]  = beat_ff;
   assign chain_valid[0] = inject_ff;
   assign chain_index[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      kvt_cell #(
         .INDEX (i),
         .KW    (KW),
         .VW    (VW),
         .IW    (IW),
         .FW    (FW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .fill     (fill_ff),
         .up_beat  (chain_beat[i]),
         .up_valid (chain_valid[i]),
         .up_index (chain_index[i]),
         .dn_beat  (chain_beat[i+1]),
         .dn_valid (chain_valid[i+1]),
         .dn_index (chain_index[i+1])
      );
      assign cell_busy[i] = chain_valid[i+1];
   end

   assign last_beat  = chain_beat[DEPTH];
   assign last_valid = chain_valid[DEPTH];
   assign last_idx32 = 32'(chain_index[DEPTH]);

   // control: state and fill count
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_BUSY;
         S_BUSY: begin
            if (last_valid) begin
               state_in = S_IDLE;
               if (last_beat.op == OP_PUSH && last_beat.app) fill_in = fill_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         inject_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         inject_ff <= accept;
         strobe_ff <= last_valid;
      end
   end

   // response formatting
   always_comb begin
      found_in  = 1'b0;
      index_in  = '0;
      ekey_in   = '0;
      evalue_in = '0;
      status_in = ST_OK;
      case (last_beat.op)
         OP_PUSH: begin
            if (last_beat.hit || last_beat.app) begin
               found_in  = last_beat.hit;
               index_in  = last_idx32[6:0];
               ekey_in   = last_beat.key;
               evalue_in = last_beat.value;
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_LOOKUP, OP_READ: begin
            if (last_beat.hit) begin
               found_in  = 1'b1;
               index_in  = last_idx32[6:0];
               ekey_in   = last_beat.key;
               evalue_in = last_beat.value;
            end else begin
               status_in = (last_beat.op == OP_READ) ? ST_RANGE : ST_NOT_FOUND;
            end
         end
         OP_DELETE: begin
            if (last_beat.hit) begin
               found_in = 1'b1;
               index_in = last_idx32[6:0];
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         OP_CLEAR: status_in = ST_OK;
         default:  status_in = ST_RANGE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (last_valid) begin
         found_ff  <= found_in;
         index_ff  <= index_in;
         ekey_ff   <= ekey_in;
         evalue_ff <= evalue_in;
         status_ff <= status_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_found       = found_ff;
   assign rsp_entry_index = index_ff;
   assign rsp_entry_key   = ekey_ff;
   assign rsp_entry_value = evalue_ff;
   assign rsp_status      = status_ff;

   // checks
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_busy) <= 1)
      else $error("more than one beat in the cell row");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL)
      else $error("fill count past depth");

   a_fill_mono: assert property (@(posedge clock) disable iff (reset)
      ##1 (fill_ff == $past(fill_ff) || fill_ff == $past(fill_ff) + 1'b1))
      else $error("fill count moved other than up by one");

   a_strobe_end: assert property (@(posedge clock) disable iff (reset)
      last_valid |=> (rsp_strobe && state_ff == S_IDLE))
      else $error("response not strobed at end of walk");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> fill_ff == FULL_FILL)
      else $error("table full reported below depth");

endmodule
